// File: src/dsaf_pkg.sv
// shared constants and register codes for the damped spring anchor force block
package dsaf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int IO_W       = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 31;

    localparam logic [COEF_W-1:0] STIFF_RST    = 31'd65536;
    localparam logic [COEF_W-1:0] MIN_DIST_RST = 31'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ANCHOR_X = 3'd0,
        REG_ANCHOR_Y = 3'd1,
        REG_ANCHOR_Z = 3'd2,
        REG_REST_LEN = 3'd3,
        REG_STIFF    = 3'd4,
        REG_DAMPING  = 3'd5,
        REG_MIN_DIST = 3'd6
    } cfg_reg_t;

endpackage

// File: src/damped_spring_anchor_force.sv
// damped spring force toward a fixed anchor, fully pipelined
// fixed-point values, Q16.16 at the default FRAC_BITS
// throughput: one request per cycle; the whole pipe advances together and holds
//   while a finished result waits at the output register
// the depth is set by the 34 one-bit stages of the square root and the
//   FRAC_BITS + 1 one-bit stages of the three unit-vector dividers
// reset (aresetn low, synchronous) clears all valid bits and loads the
//   register defaults; payload registers are not reset
module damped_spring_anchor_force #(
    parameter int FRAC_BITS = dsaf_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = dsaf_pkg::WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [6*dsaf_pkg::IO_W-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // force_x, force_y, force_z
    output logic [3*dsaf_pkg::IO_W-1:0]         m_tdata,
    // applied, saturated
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [dsaf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dsaf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dsaf_pkg::*;

    // offset, square-sum and root widths follow from the 32-bit ports
    localparam int DW    = IO_W + 1;          // anchor - pos
    localparam int SQW   = 2 * DW;            // squared magnitude
    localparam int RW    = 34;                // floor sqrt of the 66-bit sum
    localparam int RADW  = 2 * RW;
    localparam int REMW  = RW + 2;
    localparam int QB    = FRAC_BITS + 1;     // unit vector magnitude <= 1.0
    localparam int NW    = FRAC_BITS + 2;
    localparam int DREMW = RW + 1;
    localparam int VPW   = IO_W + NW;
    localparam int VSW   = VPW + 2;
    localparam int VNW   = VSW - FRAC_BITS;
    localparam int RRW   = RW + 2;
    localparam int SPW   = IO_W + RRW;
    localparam int SW    = SPW - FRAC_BITS;
    localparam int DPW   = IO_W + VNW;
    localparam int DTW   = DPW - FRAC_BITS;
    localparam int SCW   = ((SW > DTW) ? SW : DTW) + 1;
    localparam int FPW   = NW + SCW;
    localparam int FW    = FPW - FRAC_BITS;
    localparam int CLW   = ((FW > WORD_BITS) ? FW : WORD_BITS) + 1;

    localparam logic signed [CLW-1:0] WHI =
        {{(CLW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [CLW-1:0] WLO = ~WHI;
    localparam logic [QB-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // whole pipe moves when the output register is free or being drained
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // configuration registers
    logic signed [IO_W-1:0]   anchor_reg [3];
    logic        [COEF_W-1:0] rest_reg, stiff_reg, damp_reg, min_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_reg[0] <= '0;
            anchor_reg[1] <= '0;
            anchor_reg[2] <= '0;
            rest_reg      <= '0;
            stiff_reg     <= STIFF_RST;
            damp_reg      <= '0;
            min_dist_reg  <= MIN_DIST_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ANCHOR_X: anchor_reg[0] <= cfg_wdata[IO_W-1:0];
                REG_ANCHOR_Y: anchor_reg[1] <= cfg_wdata[IO_W-1:0];
                REG_ANCHOR_Z: anchor_reg[2] <= cfg_wdata[IO_W-1:0];
                REG_REST_LEN: rest_reg      <= cfg_wdata[COEF_W-1:0];
                REG_STIFF:    stiff_reg     <= cfg_wdata[COEF_W-1:0];
                REG_DAMPING:  damp_reg      <= cfg_wdata[COEF_W-1:0];
                REG_MIN_DIST: min_dist_reg  <= cfg_wdata[COEF_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- stage 1: offset d = anchor - pos ----------------
    logic                   s1_vld_reg;
    logic signed [DW-1:0]   s1_d_reg [3];
    logic signed [IO_W-1:0] s1_v_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_vld_reg <= 1'b0;
        else if (ce)  s1_vld_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s1_d_reg[i] <= DW'(anchor_reg[i]) - DW'($signed(s_tdata[i*IO_W +: IO_W]));
                s1_v_reg[i] <= s_tdata[(i+3)*IO_W +: IO_W];
            end
        end
    end

    // ---------------- stage 2: squares ----------------
    logic                   s2_vld_reg;
    logic        [SQW-1:0]  s2_sq_reg [3];
    logic signed [DW-1:0]   s2_d_reg  [3];
    logic signed [IO_W-1:0] s2_v_reg  [3];
    logic        [DW-1:0]   s2_mag    [3];

    always_comb begin
        for (int i = 0; i < 3; i++)
            s2_mag[i] = s1_d_reg[i][DW-1] ? DW'(-s1_d_reg[i]) : DW'(s1_d_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_vld_reg <= 1'b0;
        else if (ce)  s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s2_sq_reg[i] <= SQW'(s2_mag[i]) * SQW'(s2_mag[i]);
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_v_reg[i]  <= s1_v_reg[i];
            end
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic                   s3_vld_reg;
    logic        [SQW-1:0]  s3_sum_reg;
    logic signed [DW-1:0]   s3_d_reg [3];
    logic signed [IO_W-1:0] s3_v_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_vld_reg <= 1'b0;
        else if (ce)  s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_sum_reg <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_d_reg   <= s2_d_reg;
            s3_v_reg   <= s2_v_reg;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    logic                   sq_vld_reg  [RW];
    logic        [RADW-1:0] sq_rad_reg  [RW];
    logic        [REMW-1:0] sq_rem_reg  [RW];
    logic        [RW-1:0]   sq_root_reg [RW];
    logic signed [DW-1:0]   sq_d_reg    [RW][3];
    logic signed [IO_W-1:0] sq_v_reg    [RW][3];

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic                   vld_in;
        logic        [RADW-1:0] rad_in;
        logic        [REMW-1:0] rem_in;
        logic        [RW-1:0]   root_in;
        logic signed [DW-1:0]   d_in [3];
        logic signed [IO_W-1:0] v_in [3];
        logic        [REMW-1:0] rem_shift, trial;
        logic                   ge;

        if (k == 0) begin : g_first
            always_comb begin
                vld_in  = s3_vld_reg;
                rad_in  = RADW'(s3_sum_reg);
                rem_in  = '0;
                root_in = '0;
                d_in    = s3_d_reg;
                v_in    = s3_v_reg;
            end
        end else begin : g_rest
            always_comb begin
                vld_in  = sq_vld_reg[k-1];
                rad_in  = sq_rad_reg[k-1];
                rem_in  = sq_rem_reg[k-1];
                root_in = sq_root_reg[k-1];
                d_in    = sq_d_reg[k-1];
                v_in    = sq_v_reg[k-1];
            end
        end

        always_comb begin
            rem_shift = {rem_in[REMW-3:0], rad_in[RADW-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = rem_shift >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) sq_vld_reg[k] <= 1'b0;
            else if (ce)  sq_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_rem_reg[k]  <= ge ? (rem_shift - trial) : rem_shift;
                sq_root_reg[k] <= {root_in[RW-2:0], ge};
                sq_rad_reg[k]  <= rad_in << 2;
                sq_d_reg[k]    <= d_in;
                sq_v_reg[k]    <= v_in;
            end
        end
    end

    // ---------------- stage E: distance test, offset magnitudes ----------------
    logic                   e_vld_reg, e_app_reg;
    logic        [RW-1:0]   e_r_reg;
    logic signed [RRW-1:0]  e_rr_reg;
    logic        [DW-1:0]   e_mag_reg [3];
    logic                   e_neg_reg [3];
    logic signed [IO_W-1:0] e_v_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) e_vld_reg <= 1'b0;
        else if (ce)  e_vld_reg <= sq_vld_reg[RW-1];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_r_reg   <= sq_root_reg[RW-1];
            e_app_reg <= sq_root_reg[RW-1] > RW'(min_dist_reg);
            e_rr_reg  <= $signed(RRW'(sq_root_reg[RW-1])) - $signed(RRW'(rest_reg));
            e_v_reg   <= sq_v_reg[RW-1];
            for (int i = 0; i < 3; i++) begin
                e_neg_reg[i] <= sq_d_reg[RW-1][i][DW-1];
                e_mag_reg[i] <= sq_d_reg[RW-1][i][DW-1] ? DW'(-sq_d_reg[RW-1][i])
                                                       : DW'(sq_d_reg[RW-1][i]);
            end
        end
    end

    // ---------------- unit vector: |d| * 2^F / r, one quotient bit per stage ----------------
    logic                   dv_vld_reg [QB];
    logic                   dv_app_reg [QB];
    logic        [RW-1:0]   dv_r_reg   [QB];
    logic signed [RRW-1:0]  dv_rr_reg  [QB];
    logic        [DREMW-1:0] dv_rem_reg [QB][3];
    logic        [QB-1:0]   dv_q_reg   [QB][3];
    logic                   dv_neg_reg [QB][3];
    logic signed [IO_W-1:0] dv_v_reg   [QB][3];

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic                    vld_in, app_in;
        logic        [RW-1:0]    r_in;
        logic signed [RRW-1:0]   rr_in;
        logic        [DREMW-1:0] rem_shift [3];
        logic        [QB-1:0]    q_in      [3];
        logic                    neg_in    [3];
        logic signed [IO_W-1:0]  v_in      [3];
        logic                    ge        [3];

        if (j == 0) begin : g_first
            always_comb begin
                vld_in = e_vld_reg;
                app_in = e_app_reg;
                r_in   = e_r_reg;
                rr_in  = e_rr_reg;
                neg_in = e_neg_reg;
                v_in   = e_v_reg;
                for (int i = 0; i < 3; i++) begin
                    rem_shift[i] = DREMW'(e_mag_reg[i]);
                    q_in[i]      = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                vld_in = dv_vld_reg[j-1];
                app_in = dv_app_reg[j-1];
                r_in   = dv_r_reg[j-1];
                rr_in  = dv_rr_reg[j-1];
                neg_in = dv_neg_reg[j-1];
                v_in   = dv_v_reg[j-1];
                for (int i = 0; i < 3; i++) begin
                    rem_shift[i] = {dv_rem_reg[j-1][i][DREMW-2:0], 1'b0};
                    q_in[i]      = dv_q_reg[j-1][i];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++)
                ge[i] = rem_shift[i] >= DREMW'(r_in);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_vld_reg[j] <= 1'b0;
            else if (ce)  dv_vld_reg[j] <= vld_in;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_app_reg[j] <= app_in;
                dv_r_reg[j]   <= r_in;
                dv_rr_reg[j]  <= rr_in;
                dv_neg_reg[j] <= neg_in;
                dv_v_reg[j]   <= v_in;
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[j][i] <= ge[i] ? (rem_shift[i] - DREMW'(r_in)) : rem_shift[i];
                    dv_q_reg[j][i]   <= {q_in[i][QB-2:0], ge[i]};
                end
            end
        end
    end

    // ---------------- stage G1: signed unit vector ----------------
    logic                   g1_vld_reg, g1_app_reg;
    logic signed [RRW-1:0]  g1_rr_reg;
    logic signed [NW-1:0]   g1_n_reg [3];
    logic signed [IO_W-1:0] g1_v_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) g1_vld_reg <= 1'b0;
        else if (ce)  g1_vld_reg <= dv_vld_reg[QB-1];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            g1_app_reg <= dv_app_reg[QB-1];
            g1_rr_reg  <= dv_rr_reg[QB-1];
            g1_v_reg   <= dv_v_reg[QB-1];
            for (int i = 0; i < 3; i++)
                g1_n_reg[i] <= dv_neg_reg[QB-1][i] ? -$signed({1'b0, dv_q_reg[QB-1][i]})
                                                   :  $signed({1'b0, dv_q_reg[QB-1][i]});
        end
    end

    // ---------------- stage G2: v*n and stiffness*(r - rest) ----------------
    logic                   g2_vld_reg, g2_app_reg;
    logic signed [SPW-1:0]  g2_sp_reg;
    logic signed [VPW-1:0]  g2_vp_reg [3];
    logic signed [NW-1:0]   g2_n_reg  [3];
    logic signed [IO_W-1:0] stiff_s, damp_s;

    assign stiff_s = $signed({1'b0, stiff_reg});
    assign damp_s  = $signed({1'b0, damp_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) g2_vld_reg <= 1'b0;
        else if (ce)  g2_vld_reg <= g1_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            g2_app_reg <= g1_app_reg;
            g2_n_reg   <= g1_n_reg;
            g2_sp_reg  <= SPW'(stiff_s) * SPW'(g1_rr_reg);
            for (int i = 0; i < 3; i++)
                g2_vp_reg[i] <= VPW'(g1_v_reg[i]) * VPW'(g1_n_reg[i]);
        end
    end

    // ---------------- stage H: v.n and spring term rescaled ----------------
    logic                   h_vld_reg, h_app_reg;
    logic signed [VNW-1:0]  h_vn_reg;
    logic signed [SW-1:0]   h_s_reg;
    logic signed [NW-1:0]   h_n_reg [3];
    logic signed [VSW-1:0]  h_vsum;

    assign h_vsum = VSW'(g2_vp_reg[0]) + VSW'(g2_vp_reg[1]) + VSW'(g2_vp_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) h_vld_reg <= 1'b0;
        else if (ce)  h_vld_reg <= g2_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_app_reg <= g2_app_reg;
            h_n_reg   <= g2_n_reg;
            h_vn_reg  <= VNW'(h_vsum >>> FRAC_BITS);
            h_s_reg   <= SW'(g2_sp_reg >>> FRAC_BITS);
        end
    end

    // ---------------- stage I: damping * v.n ----------------
    logic                   i_vld_reg, i_app_reg;
    logic signed [DPW-1:0]  i_dp_reg;
    logic signed [SW-1:0]   i_s_reg;
    logic signed [NW-1:0]   i_n_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) i_vld_reg <= 1'b0;
        else if (ce)  i_vld_reg <= h_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            i_app_reg <= h_app_reg;
            i_n_reg   <= h_n_reg;
            i_s_reg   <= h_s_reg;
            i_dp_reg  <= DPW'(damp_s) * DPW'(h_vn_reg);
        end
    end

    // ---------------- stage J: scalar = spring - damper ----------------
    logic                   j_vld_reg, j_app_reg;
    logic signed [SCW-1:0]  j_scal_reg;
    logic signed [NW-1:0]   j_n_reg [3];
    logic signed [DTW-1:0]  j_dt;

    assign j_dt = DTW'(i_dp_reg >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) j_vld_reg <= 1'b0;
        else if (ce)  j_vld_reg <= i_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            j_app_reg  <= i_app_reg;
            j_n_reg    <= i_n_reg;
            j_scal_reg <= SCW'(i_s_reg) - SCW'(j_dt);
        end
    end

    // ---------------- stage K: n * scalar per axis ----------------
    logic                   k_vld_reg, k_app_reg;
    logic signed [FPW-1:0]  k_fp_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) k_vld_reg <= 1'b0;
        else if (ce)  k_vld_reg <= j_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k_app_reg <= j_app_reg;
            for (int i = 0; i < 3; i++)
                k_fp_reg[i] <= FPW'(j_n_reg[i]) * FPW'(j_scal_reg);
        end
    end

    // ---------------- output register: rescale, clamp, zero when too close ----------------
    logic                   out_vld_reg;
    logic [3*IO_W-1:0]      out_data_reg;
    logic [1:0]             out_user_reg;
    logic signed [CLW-1:0]  f_wide [3];
    logic signed [CLW-1:0]  f_clip [3];
    logic [2:0]             f_sat;
    logic [3*IO_W-1:0]      out_data_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_wide[i] = CLW'(FW'(k_fp_reg[i] >>> FRAC_BITS));
            f_sat[i]  = (f_wide[i] > WHI) || (f_wide[i] < WLO);
            if (f_wide[i] > WHI)      f_clip[i] = WHI;
            else if (f_wide[i] < WLO) f_clip[i] = WLO;
            else                      f_clip[i] = f_wide[i];
            out_data_next[i*IO_W +: IO_W] = k_app_reg ? IO_W'(f_clip[i]) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (ce)  out_vld_reg <= k_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= out_data_next;
            out_user_reg <= {k_app_reg && (|f_sat), k_app_reg};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ---------------- checks ----------------
    // root stage leaves a remainder no larger than twice the root
    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld_reg[RW-1] |-> sq_rem_reg[RW-1] <= REMW'({sq_root_reg[RW-1], 1'b0}))
        else $error("sqrt remainder out of bound");

    // unit vector components never exceed 1.0
    a_unit_q: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[QB-1] && dv_app_reg[QB-1] |->
            dv_q_reg[QB-1][0] <= Q_ONE && dv_q_reg[QB-1][1] <= Q_ONE &&
            dv_q_reg[QB-1][2] <= Q_ONE)
        else $error("unit vector component above one");

    // clamping is only reported on an applied force
    a_sat_app: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("saturated without applied");

    // no force leaves the block when the body is within the minimum distance of the anchor
    a_zero_force: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero force with applied clear");

endmodule
